// ----- src/glo_pkg.sv -----
package glo_pkg;

  localparam int COORD_W      = 10;
  localparam int TOTAL_W      = 21;
  localparam int CELL_W       = 2;
  localparam int GRID_DIM_DEF = 1024;

  localparam logic [CELL_W-1:0]  HIT_CAP   = CELL_W'(2);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [TOTAL_W-1:0] overlap_total;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load_seg;
    logic walk;
    logic load_result;
    logic result_ok;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic seg_ok;
    logic walk_last;
  } ctl_stat_t;

endpackage

// ----- src/glo_ctrl.sv -----
module glo_ctrl
  import glo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && stat.seg_ok) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_seg    = stat.seg_ok;
          cmd.load_result = !stat.seg_ok;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
      end
      ST_DRAIN: begin
        cmd.load_result = 1'b1;
        cmd.result_ok   = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/glo_datapath.sv -----
module glo_datapath
  import glo_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      request,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat,
  output rsp_t      result,
  output logic      done
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  logic [CELL_W-1:0] mem [DEPTH];

  logic [AW-1:0]      clr_addr;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] remaining;
  logic               x_inc;
  logic               x_dec;
  logic               y_inc;
  logic               y_dec;
  logic               s1_valid;
  logic [AW-1:0]      s1_addr;
  logic [CELL_W-1:0]  rd_data;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;

  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic               in_range;
  logic [AW-1:0]      cur_addr;
  logic [CELL_W-1:0]  cell_next;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [CELL_W-1:0]  wr_data;

  // segment check on the incoming request, clear and walk end flags
  always_comb begin
    adx = (request.end_x >= request.start_x) ? request.end_x - request.start_x
                                             : request.start_x - request.end_x;
    ady = (request.end_y >= request.start_y) ? request.end_y - request.start_y
                                             : request.start_y - request.end_y;
    stat.seg_ok     = (adx == '0) || (ady == '0) || (adx == ady);
    stat.clear_last = &clr_addr;
    stat.walk_last  = (remaining == '0);
  end

  assign in_range = (int'(cur_x) < GRID_DIM) && (int'(cur_y) < GRID_DIM);
  assign cur_addr = {CW'(cur_x), CW'(cur_y)};

  // cell update, running total and cell store write select
  always_comb begin
    cell_next  = (rd_data < HIT_CAP) ? rd_data + CELL_W'(1) : rd_data;
    total_next = total;
    if (s1_valid && (rd_data == CELL_W'(1)) && (total != TOTAL_MAX)) begin
      total_next = total + TOTAL_W'(1);
    end
    wr_en   = cmd.clear_en || s1_valid;
    wr_addr = cmd.clear_en ? clr_addr : s1_addr;
    wr_data = cmd.clear_en ? '0 : cell_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.walk) begin
      rd_data <= mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      s1_valid <= 1'b0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clear_en) clr_addr <= clr_addr + AW'(1);
      s1_valid <= cmd.walk && in_range;
      total    <= total_next;
      done     <= cmd.load_result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      cur_x     <= request.start_x;
      cur_y     <= request.start_y;
      remaining <= (adx > ady) ? adx : ady;
      x_inc     <= request.end_x > request.start_x;
      x_dec     <= request.end_x < request.start_x;
      y_inc     <= request.end_y > request.start_y;
      y_dec     <= request.end_y < request.start_y;
    end else if (cmd.walk) begin
      if (x_inc) cur_x <= cur_x + COORD_W'(1);
      if (x_dec) cur_x <= cur_x - COORD_W'(1);
      if (y_inc) cur_y <= cur_y + COORD_W'(1);
      if (y_dec) cur_y <= cur_y - COORD_W'(1);
      remaining <= remaining - COORD_W'(1);
    end
    if (cmd.walk) begin
      s1_addr <= cur_addr;
    end
    if (cmd.load_result) begin
      result.accepted      <= cmd.result_ok;
      result.overlap_total <= total_next;
    end
  end

`ifndef SYNTHESIS
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    total >= $past(total))
    else $error("overlap total went down");

  a_result_total: assert property (@(posedge clk) disable iff (rst)
    done |-> result.overlap_total == total)
    else $error("reported total differs from running total");

  a_clear_no_writeback: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en |-> !s1_valid)
    else $error("cell writeback during clearing pass");
`endif

endmodule

// ----- src/grid_line_overlap_counter.sv -----
// channel   ports                      handshake
// ------------------------------------------------------------------
// request   request (req_t)            taken when start && !busy
// result    result (rsp_t), done       done high for a single cycle per request, no stall
//
// after reset a clearing pass zeroes every cell of the cell store;
// busy stays high until it ends.
// a drawn segment is walked cell by cell from its start point, one
// read-modify-write of the cell store per cycle. a rejected segment
// is answered without a walk. done rises the cycle after the last
// writeback and a new request may be taken in that same cycle.
module grid_line_overlap_counter
  import glo_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  glo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  glo_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

// ----- tb/tb_grid_line_overlap_counter.sv -----
`timescale 1ns / 100ps

module tb_grid_line_overlap_counter;
  import glo_pkg::*;

  localparam int GRID = GRID_DIM_DEF;
  localparam int CLK_HALF = 5;
  localparam int CLEAR_CYCLES = 1 << (2 * $clog2(GRID));
  localparam int WATCHDOG_LIMIT = 4 * CLEAR_CYCLES + 8 * GRID;
  localparam int RANDOM_ITEMS = 560;
  localparam int CALM_TAIL = 60;
  localparam int COORD_MAX = (1 << COORD_W) - 1;

  typedef struct {
    req_t seg;
    bit   drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;

  pending_t pending[$];
  rsp_t     totals_due[$];

  bit [CELL_W-1:0]  hit_map [GRID * GRID];
  logic [TOTAL_W-1:0] overlap_tally = '0;

  int item_total = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int gap_left = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  grid_line_overlap_counter #(
    .GRID_DIM(GRID)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #CLK_HALF clk = ~clk;

  // walks one segment over the hit map and returns the running total
  function automatic rsp_t draw_segment(req_t seg);
    int x0, y0, dx, dy, adx, ady, ux, uy, span, col, row, idx;
    bit ok;
    rsp_t r;
    x0 = int'(seg.start_x);
    y0 = int'(seg.start_y);
    dx = int'(seg.end_x) - x0;
    dy = int'(seg.end_y) - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    ok = (dx == 0) || (dy == 0) || (adx == ady);
    if (ok) begin
      ux = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      uy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      span = (adx > ady) ? adx : ady;
      for (int i = 0; i <= span; i++) begin
        col = x0 + i * ux;
        row = y0 + i * uy;
        if (col >= 0 && row >= 0 && col < GRID && row < GRID) begin
          idx = col * GRID + row;
          if (hit_map[idx] < HIT_CAP) begin
            hit_map[idx] = hit_map[idx] + 1'b1;
            if (hit_map[idx] == HIT_CAP && overlap_tally != TOTAL_MAX)
              overlap_tally = overlap_tally + 1'b1;
          end
        end
      end
    end
    r.accepted = ok;
    r.overlap_total = overlap_tally;
    return r;
  endfunction

  function automatic int step_coord(int s, int len, bit down);
    if ((down && s >= len) || s + len > COORD_MAX)
      return s - len;
    return s + len;
  endfunction

  task automatic add_segment(int ax, int ay, int bx, int by, bit drain);
    pending_t p;
    p.seg.start_x = COORD_W'(ax);
    p.seg.start_y = COORD_W'(ay);
    p.seg.end_x = COORD_W'(bx);
    p.seg.end_y = COORD_W'(by);
    p.drain_first = drain;
    pending.push_back(p);
    item_total++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_requests
    logic take, show;
    int sent_now;
    take = start && !busy;
    show = start && !take;
    sent_now = requests_sent;
    if (!rst) begin
      if (take) begin
        totals_due.push_back(draw_segment(request));
        void'(pending.pop_front());
        sent_now++;
        requests_sent <= sent_now;
        if (sent_now < item_total - CALM_TAIL && $urandom_range(0, 99) < 30)
          gap_left = $urandom_range(1, 9);
      end
      if (!show && pending.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].drain_first || results_seen == sent_now) begin
          show = 1'b1;
          request <= pending[0].seg;
        end
      end
    end
    start <= show;
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (totals_due.size() == 0) begin
        report_mismatch("result with no request outstanding, total",
                        int'(result.overlap_total), 0);
      end else begin
        want = totals_due.pop_front();
        if (result.accepted !== want.accepted)
          report_mismatch("accepted", int'(result.accepted), int'(want.accepted));
        if (result.overlap_total !== want.overlap_total)
          report_mismatch("overlap_total", int'(result.overlap_total),
                          int'(want.overlap_total));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_grid_line_overlap_counter failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int kind, spot, bx, by, sx, sy, len, ex, ey;
    bit drain;

    // single points, repeated point, full-span lines in every direction
    add_segment(0, 0, 0, 0, 1'b0);
    add_segment(0, 0, 0, 0, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    add_segment(0, 0, COORD_MAX, 0, 1'b0);
    add_segment(COORD_MAX, 0, 0, 0, 1'b0);
    add_segment(0, 0, 0, COORD_MAX, 1'b0);
    add_segment(0, COORD_MAX, 0, 0, 1'b0);
    add_segment(0, 0, COORD_MAX, COORD_MAX, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, 0, 0, 1'b0);
    add_segment(0, COORD_MAX, COORD_MAX, 0, 1'b0);
    add_segment(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, COORD_MAX, 0, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX, 1'b0);
    // rejected segments leave the total unchanged
    add_segment(0, 0, 1, 2, 1'b0);
    add_segment(0, 1, COORD_MAX, 0, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, 0, 1, 1'b0);
    add_segment(5, 7, 9, 12, 1'b0);
    // short overlapping diagonals and short straight lines
    add_segment(10, 10, 12, 12, 1'b0);
    add_segment(12, 12, 10, 10, 1'b0);
    add_segment(12, 10, 10, 12, 1'b0);
    add_segment(10, 11, 12, 11, 1'b0);
    add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      drain = (n == 0) || (n == RANDOM_ITEMS / 2);
      kind = $urandom_range(0, 99);
      spot = $urandom_range(0, 3);
      case (spot)
        0: begin
          bx = 0;
          by = 0;
        end
        1: begin
          bx = COORD_MAX - 31;
          by = COORD_MAX - 31;
        end
        2: begin
          bx = 480;
          by = 512;
        end
        default: begin
          bx = $urandom_range(0, COORD_MAX - 31);
          by = $urandom_range(0, COORD_MAX - 31);
        end
      endcase
      sx = bx + $urandom_range(0, 31);
      sy = by + $urandom_range(0, 31);
      len = $urandom_range(0, 15);
      if (kind < 3) begin
        case ($urandom_range(0, 3))
          0: add_segment(0, sy, COORD_MAX, sy, drain);
          1: add_segment(sx, COORD_MAX, sx, 0, drain);
          2: add_segment(0, 0, COORD_MAX, COORD_MAX, drain);
          default: add_segment(COORD_MAX, 0, 0, COORD_MAX, drain);
        endcase
      end else if (kind < 8) begin
        add_segment($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), drain);
      end else if (kind < 18) begin
        ex = step_coord(sx, $urandom_range(1, 15), 1'($urandom_range(0, 1)));
        ey = step_coord(sy, $urandom_range(1, 15), 1'($urandom_range(0, 1)));
        add_segment(sx, sy, ex, ey, drain);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            ex = step_coord(sx, len, 1'($urandom_range(0, 1)));
            ey = sy;
          end
          1: begin
            ex = sx;
            ey = step_coord(sy, len, 1'($urandom_range(0, 1)));
          end
          default: begin
            ex = step_coord(sx, len, 1'($urandom_range(0, 1)));
            ey = step_coord(sy, len, 1'($urandom_range(0, 1)));
          end
        endcase
        add_segment(sx, sy, ex, ey, drain);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent < item_total || results_seen < item_total)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (totals_due.size() != 0)
      report_mismatch("requests never answered", totals_due.size(), 0);
    if (mismatches == 0) begin
      $display("tb_grid_line_overlap_counter passed");
    end else begin
      $display("tb_grid_line_overlap_counter failed");
    end
    $finish;
  end

endmodule
